// ----- sv/fasr_pkg.sv -----
// package for the fraction add/subtract/reduce block
// constants and the function and status enum types; no dependencies
package fasr_pkg;

  localparam int OperandWidthDefault = 16;
  localparam int NumOutBits = 33;
  localparam int DenOutBits = 32;
  localparam int QueueDepth = 2;

  typedef enum logic {
    FUNC_ADD = 1'b0,
    FUNC_SUB = 1'b1
  } func_t;

  typedef enum logic {
    STATUS_OK = 1'b0,
    STATUS_ZERO_DEN = 1'b1
  } status_t;

endpackage

// ----- sv/fasr_if.sv -----
// valid/ready channel interfaces for the fraction block
// depends on nothing; input widths set by parameter W, output widths fixed
interface fasr_in_if #(
  parameter int W = 16
);
  logic valid;
  logic ready;
  logic func;
  logic signed [W-1:0] a_num;
  logic [W-1:0] a_den;
  logic signed [W-1:0] b_num;
  logic [W-1:0] b_den;

  modport source(output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface fasr_out_if;
  logic valid;
  logic ready;
  logic signed [32:0] res_num;
  logic [31:0] res_den;
  logic status;

  modport source(output valid, res_num, res_den, status, input ready);
  modport sink(input valid, res_num, res_den, status, output ready);
endinterface

// ----- sv/fasr_front.sv -----
// front end: accepts items, flags zero denominators, forms cross products
// depends on fasr_pkg and fasr_if
module fasr_front #(
  parameter int W = fasr_pkg::OperandWidthDefault
) (
  input  logic clk,
  input  logic rst,
  fasr_in_if.sink in_ch,
  output logic q_push,
  input  logic q_full,
  output logic [2*W+1:0] q_num,
  output logic [2*W-1:0] q_den,
  output logic q_err
);
  import fasr_pkg::*;

  // two stages: register inputs, then multiply and sum
  logic s1_valid;
  logic s1_sub;
  logic s1_err;
  logic signed [W-1:0] an, bn;
  logic [W-1:0] ad, bd;
  logic s2_valid;
  logic s2_sub;
  logic s2_err;
  logic signed [2*W:0] p, q;
  logic [2*W-1:0] d;

  logic s2_go;
  logic s1_go;

  assign s2_go = !s2_valid || !q_full;
  assign s1_go = !s1_valid || s2_go;
  assign in_ch.ready = s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_go) s1_valid <= in_ch.valid;
      if (s2_go) s2_valid <= s1_valid;
    end
    if (s1_go && in_ch.valid) begin
      s1_sub <= in_ch.func;
      s1_err <= (in_ch.a_den == '0) || (in_ch.b_den == '0);
      an <= in_ch.a_num;
      ad <= in_ch.a_den;
      bn <= in_ch.b_num;
      bd <= in_ch.b_den;
    end
    if (s2_go && s1_valid) begin
      s2_sub <= s1_sub;
      s2_err <= s1_err;
      p <= (2*W+1)'($signed({{(W+1){an[W-1]}}, an}) * $signed({{(W+1){1'b0}}, bd}));
      q <= (2*W+1)'($signed({{(W+1){bn[W-1]}}, bn}) * $signed({{(W+1){1'b0}}, ad}));
      d <= ad * bd;
    end
  end

  logic signed [2*W+1:0] n;
  always_comb begin
    if (s2_sub == FUNC_SUB) n = {p[2*W], p} - {q[2*W], q};
    else n = {p[2*W], p} + {q[2*W], q};
  end

  assign q_push = s2_valid && !q_full;
  assign q_num = n;
  assign q_den = d;
  assign q_err = s2_err;
endmodule

// ----- sv/fasr_queue.sv -----
// small fifo between front and back ends
// depends on fasr_pkg
module fasr_queue #(
  parameter int DW = 8,
  parameter int DEPTH = fasr_pkg::QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [DW-1:0] wdata,
  output logic full,
  input  logic pop,
  output logic [DW-1:0] rdata,
  output logic empty
);
  import fasr_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full = cnt == (AW+1)'(DEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= wdata;
  end
endmodule

// ----- sv/fasr_back.sv -----
// back end: binary gcd, two restoring divisions, result register
// depends on fasr_pkg and fasr_if
module fasr_back #(
  parameter int W = fasr_pkg::OperandWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic q_pop,
  input  logic [2*W+1:0] q_num,
  input  logic [2*W-1:0] q_den,
  input  logic q_err,
  fasr_out_if.source out_ch
);
  import fasr_pkg::*;

  localparam int MW = 2*W + 1;  // magnitude width
  localparam int CW = $clog2(MW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_GCD, S_SHIFT, S_DIVN, S_DIVD, S_OUT
  } state_t;

  state_t state;
  logic neg;
  logic [MW-1:0] mag, den, x, y, g;
  logic [CW-1:0] k;
  logic [CW-1:0] bitc;
  logic [MW-1:0] quo, rem;
  logic [MW-1:0] qn;
  logic [MW:0] trial;
  logic [MW-1:0] dividend;

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign dividend = (state == S_DIVN) ? mag : den;
  assign trial = {rem, dividend[bitc]} - {1'b0, g};

  logic [MW-1:0] mag_in;
  assign mag_in = q_num[2*W+1] ? MW'(-q_num) : q_num[MW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (q_pop) begin
          neg <= q_num[2*W+1];
          mag <= mag_in;
          den <= MW'(q_den);
          x <= mag_in;
          y <= MW'(q_den);
          k <= '0;
          if (q_err || mag_in == '0) begin
            out_ch.res_num <= '0;
            out_ch.res_den <= 32'd1;
            out_ch.status <= q_err ? STATUS_ZERO_DEN : STATUS_OK;
            out_ch.valid <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // stein's algorithm, one step a cycle
          if (x == y) begin
            g <= x;
            state <= S_SHIFT;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1; y <= y >> 1; k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x > y) begin
            x <= (x - y) >> 1;
          end else begin
            y <= (y - x) >> 1;
          end
        end
        S_SHIFT: begin
          g <= g << k;
          bitc <= CW'(MW-1);
          rem <= '0;
          state <= S_DIVN;
        end
        S_DIVN, S_DIVD: begin
          if (!trial[MW]) begin
            rem <= trial[MW-1:0];
            quo <= {quo[MW-2:0], 1'b1};
          end else begin
            rem <= {rem[MW-2:0], dividend[bitc]};
            quo <= {quo[MW-2:0], 1'b0};
          end
          if (bitc == '0) begin
            bitc <= CW'(MW-1);
            rem <= '0;
            if (state == S_DIVN) begin
              qn <= {quo[MW-2:0], !trial[MW]};
              state <= S_DIVD;
            end else begin
              out_ch.res_num <= neg ? NumOutBits'(-{1'b0, qn}) : NumOutBits'(qn);
              out_ch.res_den <= DenOutBits'({quo[MW-2:0], !trial[MW]});
              out_ch.status <= STATUS_OK;
              out_ch.valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            bitc <= bitc - 1'b1;
          end
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/fraction_add_sub_reduce.sv -----
// fraction add/subtract with gcd reduction: two-stage front end forms
// n = a_num*b_den +/- b_num*a_den and d = a_den*b_den, a two-entry queue
// feeds a back end that runs a binary gcd and two restoring divisions
// on one item at a time, popping the next entry only when idle; a zero
// denominator or zero sum skips both and gives 0/1 (zero den flagged).
// synchronous active-high reset clears all valids and the queue.
module fraction_add_sub_reduce #(
  parameter int OPERAND_WIDTH = fasr_pkg::OperandWidthDefault
) (
  input logic clk,
  input logic rst,
  fasr_in_if.sink in_ch,
  fasr_out_if.source out_ch
);
  import fasr_pkg::*;

  localparam int W = OPERAND_WIDTH;
  localparam int QW = (2*W+2) + 2*W + 1;

  // front to queue
  logic f_push, q_full, q_empty, q_pop;
  logic [2*W+1:0] f_num;
  logic [2*W-1:0] f_den;
  logic f_err;
  logic [QW-1:0] q_rdata;

  fasr_front #(.W(W)) u_front (
    .clk, .rst, .in_ch,
    .q_push(f_push), .q_full,
    .q_num(f_num), .q_den(f_den), .q_err(f_err)
  );

  fasr_queue #(.DW(QW), .DEPTH(QueueDepth)) u_queue (
    .clk, .rst,
    .push(f_push), .wdata({f_num, f_den, f_err}), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  // back end pops one entry and runs it to completion
  fasr_back #(.W(W)) u_back (
    .clk, .rst,
    .q_empty, .q_pop,
    .q_num(q_rdata[QW-1 -: 2*W+2]),
    .q_den(q_rdata[2*W:1]),
    .q_err(q_rdata[0]),
    .out_ch
  );
endmodule
